FILE: design/sgb_pkg.sv
package sgb_pkg;

   localparam int NUM_TAPS  = 7;
   localparam int NUM_TAIL  = 3;
   localparam int BANK_W    = 3;
   localparam int INTER_W   = 24;
   localparam int PIXEL_W   = 8;
   localparam int COEF_W    = 16;
   localparam int HEIGHT_W  = 13;

   typedef struct packed {
      logic               action;
      logic [PIXEL_W-1:0] pixel_in;
   } req_type;

   typedef struct packed {
      logic [PIXEL_W-1:0] pixel_out;
      logic               frame_last;
   } rsp_type;

   typedef struct packed {
      logic [COEF_W-1:0] center;
      logic [COEF_W-1:0] one;
      logic [COEF_W-1:0] two;
      logic [COEF_W-1:0] three;
   } coef_type;

   typedef enum logic [2:0] {
      CSR_COEF_CENTER  = 3'd0,
      CSR_COEF_ONE     = 3'd1,
      CSR_COEF_TWO     = 3'd2,
      CSR_COEF_THREE   = 3'd3,
      CSR_RADIUS       = 3'd4,
      CSR_FRAME_WIDTH  = 3'd5,
      CSR_FRAME_HEIGHT = 3'd6
   } csr_index_type;

   typedef logic [NUM_TAPS-1:0][PIXEL_W-1:0] window_type;
   typedef logic [NUM_TAPS-1:0][INTER_W-1:0] taps_type;
   typedef logic [NUM_TAIL:0][INTER_W-1:0]   hsum_type;

   function automatic logic [COEF_W-1:0] weight(coef_type c, logic [1:0] tap_dist);
      logic [COEF_W-1:0] w;
      case (tap_dist)
         2'd0: w = c.center;
         2'd1: w = c.one;
         2'd2: w = c.two;
         default: w = c.three;
      endcase
      return w;
   endfunction

endpackage

FILE: design/sgb_hpass.sv
module sgb_hpass (
   input  sgb_pkg::window_type window,
   input  sgb_pkg::coef_type   coef,
   input  logic [1:0]          radius,
   input  logic [2:0]          x_sat,
   output sgb_pkg::hsum_type   sums
);
   import sgb_pkg::*;

   logic [26:0] acc;
   logic [23:0] prod;
   int          o;
   int          k;
   int          ad;

   // units 0..2: column at offset 0..2 left of newest pixel; unit 3: offset radius
   always_comb begin
      acc  = '0;
      prod = '0;
      o    = 0;
      k    = 0;
      ad   = 0;
      for (int u = 0; u <= NUM_TAIL; u++) begin
         o   = (u == NUM_TAIL) ? int'(radius) : u;
         acc = '0;
         for (int d = -3; d <= 3; d++) begin
            ad = (d < 0) ? -d : d;
            k  = o - d;
            if (k < 0) begin
               k = 0;
            end
            if (k > int'(x_sat)) begin
               k = int'(x_sat);
            end
            prod = 24'(weight(coef, 2'(ad))) * 24'(window[3'(k)]);
            if (ad <= int'(radius)) begin
               acc = acc + 27'(prod);
            end
         end
         sums[u] = (acc > 27'hFF_FFFF) ? 24'hFF_FFFF : acc[23:0];
      end
   end

endmodule

FILE: design/sgb_vpass.sv
module sgb_vpass (
   input  sgb_pkg::taps_type taps,
   input  sgb_pkg::coef_type coef,
   input  logic [1:0]        radius,
   input  logic              last,
   output sgb_pkg::rsp_type  result
);
   import sgb_pkg::*;

   logic [42:0] acc;
   logic [39:0] prod;
   int          ad;

   // rounding half added before the taps, then truncate and saturate
   always_comb begin
      acc  = 43'(1) << 31;
      prod = '0;
      ad   = 0;
      for (int j = 0; j < NUM_TAPS; j++) begin
         ad   = (j < 3) ? 3 - j : j - 3;
         prod = 40'(weight(coef, 2'(ad))) * 40'(taps[j]);
         if (ad <= int'(radius)) begin
            acc = acc + 43'(prod);
         end
      end
      result.pixel_out  = (acc[42:40] != 3'd0) ? 8'hFF : acc[39:32];
      result.frame_last = last;
   end

endmodule

FILE: design/separable_gaussian_blur.sv
// separable gaussian blur, 8-bit grey pixels in raster order, clamp-to-edge
// request channel: req_valid/req_ready with req_data.action (0 pixel, 1 flush)
//   and req_data.pixel_in; flush requests after the frame's last pixel push
//   out the final radius lines
// result channel: rsp_valid/rsp_ready with rsp_data.pixel_out and
//   rsp_data.frame_last, set on the bottom right pixel of the frame
// csr port: csr_we, csr_index, csr_wdata; writing radius, width or height
//   restarts the frame; write only while the block is idle
// a request makes zero or one result; the result is registered first in the read
//   stage, then in the result register
// one request per cycle while req_ready is high; the horizontal taps, the line
//   store bank write and the seven bank reads all happen in the accept cycle
// the receiver stalling holds the result register; one more result can wait
//   in the read stage, after that req_ready drops
// reset clears counters, pixel window and pipeline valids and loads the
//   default coefficients and geometry; line store contents are undefined
module separable_gaussian_blur #(
   parameter int MAX_WIDTH = 2048
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  sgb_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output sgb_pkg::rsp_type rsp_data,
   input  logic             csr_we,
   input  logic [2:0]       csr_index,
   input  logic [15:0]      csr_wdata
);
   import sgb_pkg::*;

   localparam int CW = $clog2(MAX_WIDTH);

   coef_type              coef_ff;
   logic [1:0]            radius_ff;
   logic [11:0]           width_ff;
   logic [HEIGHT_W-1:0]   height_ff;
   logic                  geo_clear;

   logic [1:0]            r_eff;
   logic [CW:0]           w_eff;
   logic [HEIGHT_W-1:0]   h_eff;

   logic [CW-1:0]         in_col_ff, in_col_in;
   logic [HEIGHT_W-1:0]   in_row_ff, in_row_in;
   logic [BANK_W-1:0]     in_mod_ff, in_mod_in;
   logic [CW-1:0]         out_col_ff, out_col_in;
   logic [HEIGHT_W-1:0]   out_row_ff, out_row_in;
   logic [BANK_W-1:0]     out_mod_ff, out_mod_in;
   window_type            window_ff, window_in, win_new;

   logic                  accept;
   logic [CW-1:0]         x;
   logic                  pix_go;
   logic                  x_last;
   logic [2:0]            x_sat;
   logic                  mem_we;
   logic [CW-1:0]         wcol;
   logic [NUM_TAIL-1:0]   tail_we;
   hsum_type              hs;

   logic [CW-1:0]         col_nx;
   logic [HEIGHT_W-1:0]   row_nx;
   logic [HEIGHT_W-1:0]   nr;
   logic [CW:0]           nc;
   logic                  emit;
   logic                  out_last;

   logic [NUM_TAPS-1:0][BANK_W-1:0] bank;
   logic [NUM_TAPS-1:0]             hit;
   logic                            tail_sel;
   logic [1:0]                      tail_t;
   int                              e_v;
   int                              s_v;

   logic [NUM_TAIL*NUM_TAPS-1:0][INTER_W-1:0] tail_ff;
   taps_type                                  rd_bus;

   logic                            s1_valid_ff;
   logic [NUM_TAPS-1:0][BANK_W-1:0] s1_bank_ff;
   logic [NUM_TAPS-1:0]             s1_hit_ff;
   logic [INTER_W-1:0]              s1_byp_ff;
   logic                            s1_tail_ff;
   logic [1:0]                      s1_t_ff;
   logic                            s1_last_ff;
   taps_type                        s1_taps;
   rsp_type                         s1_result;

   logic                            rsp_valid_ff;
   rsp_type                         rsp_ff;
   logic                            out_move;

   // configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         coef_ff.center <= 16'd34236;
         coef_ff.one    <= 16'd15663;
         coef_ff.two    <= 16'd0;
         coef_ff.three  <= 16'd0;
         radius_ff      <= 2'd1;
         width_ff       <= 12'd640;
         height_ff      <= 13'd480;
      end else if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_COEF_CENTER:  coef_ff.center <= csr_wdata;
            CSR_COEF_ONE:     coef_ff.one    <= csr_wdata;
            CSR_COEF_TWO:     coef_ff.two    <= csr_wdata;
            CSR_COEF_THREE:   coef_ff.three  <= csr_wdata;
            CSR_RADIUS:       radius_ff      <= csr_wdata[1:0];
            CSR_FRAME_WIDTH:  width_ff       <= csr_wdata[11:0];
            CSR_FRAME_HEIGHT: height_ff      <= csr_wdata[12:0];
            default: ;
         endcase
      end
   end

   assign geo_clear = csr_we && (csr_index == CSR_RADIUS || csr_index == CSR_FRAME_WIDTH ||
                                 csr_index == CSR_FRAME_HEIGHT);

   always_comb begin
      r_eff = (radius_ff == 2'd0) ? 2'd1 : radius_ff;
      if (width_ff == 12'd0) begin
         w_eff = (CW+1)'(1);
      end else if (32'(width_ff) > MAX_WIDTH) begin
         w_eff = (CW+1)'(MAX_WIDTH);
      end else begin
         w_eff = (CW+1)'(width_ff);
      end
      if (height_ff == 13'd0) begin
         h_eff = 13'd1;
      end else if (height_ff > 13'd4096) begin
         h_eff = 13'd4096;
      end else begin
         h_eff = height_ff;
      end
   end

   // horizontal side
   assign out_move  = !rsp_valid_ff || rsp_ready;
   assign req_ready = !s1_valid_ff || out_move;
   assign accept    = req_valid && req_ready;

   always_comb begin
      x       = ({1'b0, in_col_ff} >= w_eff) ? '0 : in_col_ff;
      pix_go  = !req_data.action && (in_row_ff < h_eff);
      win_new = {window_ff[NUM_TAPS-2:0], req_data.pixel_in};
      x_last  = ({1'b0, x} == w_eff - (CW+1)'(1));
      x_sat   = (x > CW'(6)) ? 3'd6 : x[2:0];
      mem_we  = accept && pix_go && (x >= CW'(r_eff));
      wcol    = x - CW'(r_eff);
      for (int t = 0; t < NUM_TAIL; t++) begin
         tail_we[t] = accept && pix_go && x_last && (t < int'(r_eff)) && (CW'(t) <= x);
      end
   end

   sgb_hpass u_hpass (
      .window (win_new),
      .coef   (coef_ff),
      .radius (r_eff),
      .x_sat  (x_sat),
      .sums   (hs)
   );

   // position update and output readiness
   always_comb begin
      col_nx    = x;
      row_nx    = in_row_ff;
      in_mod_in = in_mod_ff;
      window_in = window_ff;
      if (pix_go) begin
         window_in = win_new;
         if (x_last) begin
            col_nx    = '0;
            row_nx    = in_row_ff + 13'd1;
            in_mod_in = (in_mod_ff == 3'd6) ? 3'd0 : in_mod_ff + 3'd1;
         end else begin
            col_nx = x + CW'(1);
         end
      end

      nr = (out_row_ff + 13'(r_eff) > h_eff - 13'd1) ? h_eff - 13'd1
                                                     : out_row_ff + 13'(r_eff);
      nc = ({1'b0, out_col_ff} + (CW+1)'(r_eff) > w_eff - (CW+1)'(1))
           ? w_eff - (CW+1)'(1) : {1'b0, out_col_ff} + (CW+1)'(r_eff);
      emit = (out_row_ff < h_eff) && ({1'b0, out_col_ff} < w_eff) &&
             ((row_nx > nr) || ((row_nx == nr) && ({1'b0, col_nx} > nc)));
      out_last = ({1'b0, out_col_ff} == w_eff - (CW+1)'(1)) &&
                 (out_row_ff == h_eff - 13'd1);

      in_col_in  = in_col_ff;
      in_row_in  = in_row_ff;
      out_col_in = out_col_ff;
      out_row_in = out_row_ff;
      out_mod_in = out_mod_ff;
      if (accept) begin
         in_col_in = col_nx;
         in_row_in = row_nx;
         if (emit) begin
            if ({1'b0, out_col_ff} == w_eff - (CW+1)'(1)) begin
               out_col_in = '0;
               out_row_in = out_row_ff + 13'd1;
               out_mod_in = (out_mod_ff == 3'd6) ? 3'd0 : out_mod_ff + 3'd1;
            end else begin
               out_col_in = out_col_ff + CW'(1);
            end
         end
      end else begin
         in_mod_in = in_mod_ff;
      end
      if (!accept) begin
         in_mod_in = in_mod_ff;
      end
      if (geo_clear || (accept && emit && out_last)) begin
         in_col_in  = '0;
         in_row_in  = '0;
         in_mod_in  = '0;
         out_col_in = '0;
         out_row_in = '0;
         out_mod_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_col_ff  <= '0;
         in_row_ff  <= '0;
         in_mod_ff  <= '0;
         out_col_ff <= '0;
         out_row_ff <= '0;
         out_mod_ff <= '0;
         window_ff  <= '0;
      end else begin
         in_col_ff  <= in_col_in;
         in_row_ff  <= in_row_in;
         in_mod_ff  <= in_mod_in;
         out_col_ff <= out_col_in;
         out_row_ff <= out_row_in;
         out_mod_ff <= out_mod_in;
         if (accept) begin
            window_ff <= window_in;
         end
      end
   end

   // bank of each vertical tap, clamped at the top and bottom rows
   always_comb begin
      e_v = 0;
      s_v = 0;
      for (int j = 0; j < NUM_TAPS; j++) begin
         if (j < 3) begin
            e_v = (int'(out_row_ff) < 3 - j) ? -int'(out_row_ff) : j - 3;
         end else begin
            e_v = (int'(h_eff) - 1 - int'(out_row_ff) < j - 3)
                  ? int'(h_eff) - 1 - int'(out_row_ff) : j - 3;
         end
         s_v = int'(out_mod_ff) + e_v + 7;
         if (s_v >= 14) begin
            s_v = s_v - 14;
         end else if (s_v >= 7) begin
            s_v = s_v - 7;
         end
         bank[j] = BANK_W'(s_v);
         hit[j]  = mem_we && (in_mod_ff == BANK_W'(s_v)) && (wcol == out_col_ff);
      end
      tail_sel = ({1'b0, out_col_ff} + (CW+1)'(r_eff) >= w_eff);
      tail_t   = 2'(w_eff - (CW+1)'(1) - {1'b0, out_col_ff});
   end

   // line store: one bank per line modulo seven
   for (genvar b = 0; b < NUM_TAPS; b++) begin : g_bank
      logic [INTER_W-1:0] mem [MAX_WIDTH];
      logic [INTER_W-1:0] rd_ff;

      always_ff @(posedge clock) begin
         if (mem_we && (in_mod_ff == BANK_W'(b))) begin
            mem[wcol] <= hs[NUM_TAIL];
         end
      end

      always_ff @(posedge clock) begin
         if (accept) begin
            rd_ff <= mem[out_col_ff];
         end
      end

      assign rd_bus[b] = rd_ff;
   end

   // last columns of each line, formed together at the line end
   always_ff @(posedge clock) begin
      for (int t = 0; t < NUM_TAIL; t++) begin
         if (tail_we[t]) begin
            tail_ff[5'(int'(in_mod_ff) * NUM_TAIL + t)] <= hs[t];
         end
      end
   end

   // read stage
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_ready) begin
         s1_valid_ff <= accept && emit;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_bank_ff <= bank;
         s1_hit_ff  <= hit;
         s1_byp_ff  <= hs[NUM_TAIL];
         s1_tail_ff <= tail_sel;
         s1_t_ff    <= tail_t;
         s1_last_ff <= out_last;
      end
   end

   always_comb begin
      for (int j = 0; j < NUM_TAPS; j++) begin
         if (s1_tail_ff) begin
            s1_taps[j] = tail_ff[5'(int'(s1_bank_ff[j]) * NUM_TAIL + int'(s1_t_ff))];
         end else if (s1_hit_ff[j]) begin
            s1_taps[j] = s1_byp_ff;
         end else begin
            s1_taps[j] = rd_bus[s1_bank_ff[j]];
         end
      end
   end

   sgb_vpass u_vpass (
      .taps   (s1_taps),
      .coef   (coef_ff),
      .radius (r_eff),
      .last   (s1_last_ff),
      .result (s1_result)
   );

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_move) begin
         rsp_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (out_move && s1_valid_ff) begin
         rsp_ff <= s1_result;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

FILE: dv/tb_top.sv
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import sgb_pkg::*;

   localparam int STORE_W = 2048;
   localparam int STALL_LIMIT = 3000;
   localparam int RANDOM_ITEMS = 80;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;
   logic    csr_we = 1'b0;
   logic [2:0]  csr_index = '0;
   logic [15:0] csr_wdata = '0;

   separable_gaussian_blur dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // blur predictor state
   logic [15:0] blur_coef [4];
   logic [1:0]  blur_radius;
   logic [11:0] blur_width;
   logic [12:0] blur_height;
   logic [7:0]  pix_window [7];
   logic [23:0] line_mem [0:7*STORE_W-1];
   int in_col, in_line, out_col, out_line;

   rsp_type expected_pixels [$];
   int errors = 0;
   int stall_count = 0;
   int hold_left = 0;
   bit idle_on = 1'b1;
   int random_sent = 0;

   function automatic int eff_radius();
      return (blur_radius == 0) ? 1 : int'(blur_radius);
   endfunction

   function automatic int eff_width();
      int w;
      w = (blur_width == 0) ? 1 : int'(blur_width);
      return (w > STORE_W) ? STORE_W : w;
   endfunction

   function automatic int eff_height();
      int h;
      h = (blur_height == 0) ? 1 : int'(blur_height);
      return (h > 4096) ? 4096 : h;
   endfunction

   function automatic longint unsigned tap_weight(int d);
      int a;
      a = (d < 0) ? -d : d;
      return longint'(blur_coef[(a > 3) ? 3 : a]);
   endfunction

   function automatic void horizontal_tap(int c, int x, int w, int r);
      longint unsigned sum;
      int col;
      int k;
      sum = 0;
      for (int d = -r; d <= r; d++) begin
         col = c + d;
         if (col < 0) col = 0;
         if (col > w - 1) col = w - 1;
         k = x - col;
         if (k < 7) sum += tap_weight(d) * pix_window[k];
      end
      if (sum > 64'hFFFFFF) sum = 64'hFFFFFF;
      line_mem[(in_line % 7) * STORE_W + (c % STORE_W)] = sum[23:0];
   endfunction

   function automatic logic [7:0] vertical_tap(int h, int r);
      longint unsigned sum;
      int line;
      sum = 64'd1 << 31;
      for (int d = -r; d <= r; d++) begin
         line = out_line + d;
         if (line < 0) line = 0;
         if (line > h - 1) line = h - 1;
         sum += tap_weight(d) * line_mem[(line % 7) * STORE_W + (out_col % STORE_W)];
      end
      sum = sum >> 32;
      return (sum > 255) ? 8'd255 : sum[7:0];
   endfunction

   function automatic void clear_frame();
      in_col = 0;
      in_line = 0;
      out_col = 0;
      out_line = 0;
   endfunction

   function automatic bit frame_idle();
      return in_col == 0 && in_line == 0 && out_col == 0 && out_line == 0;
   endfunction

   function automatic void blur_request(req_type rq);
      int w, h, r, x, c, nr, nc;
      bit last;
      rsp_type rs;
      w = eff_width();
      h = eff_height();
      r = eff_radius();
      if (in_col >= w) in_col = 0;
      if (rq.action == 1'b0 && in_line < h) begin
         x = in_col;
         for (int i = 6; i > 0; i--) pix_window[i] = pix_window[i-1];
         pix_window[0] = rq.pixel_in;
         if (x < w - 1) begin
            if (x >= r) horizontal_tap(x - r, x, w, r);
         end else begin
            for (c = (x >= r) ? x - r : 0; c <= x; c++) horizontal_tap(c, x, w, r);
         end
         in_col++;
         if (in_col == w) begin
            in_col = 0;
            in_line++;
         end
      end
      if (out_line >= h || out_col >= w) return;
      nr = (out_line + r > h - 1) ? h - 1 : out_line + r;
      nc = (out_col + r > w - 1) ? w - 1 : out_col + r;
      if (!(in_line > nr || (in_line == nr && in_col > nc))) return;
      rs.pixel_out = vertical_tap(h, r);
      last = (out_col == w - 1 && out_line == h - 1);
      rs.frame_last = last;
      expected_pixels = {expected_pixels, rs};
      if (last) begin
         clear_frame();
      end else begin
         out_col++;
         if (out_col == w) begin
            out_col = 0;
            out_line++;
         end
      end
   endfunction

   task automatic report_mismatch(string what, logic [7:0] got, logic [7:0] exp);
      $display("mismatch %s: got %0d expected %0d at %0t", what, got, exp, $realtime);
      errors++;
   endtask

   // result checker
   always @(posedge clock) begin
      rsp_type exp;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_pixels.size() == 0) begin
            report_mismatch("unexpected result", rsp_data.pixel_out, 8'd0);
         end else begin
            exp = expected_pixels.pop_front();
            if (rsp_data.pixel_out !== exp.pixel_out)
               report_mismatch("pixel_out", rsp_data.pixel_out, exp.pixel_out);
            if (rsp_data.frame_last !== exp.frame_last)
               report_mismatch("frame_last", rsp_data.frame_last, exp.frame_last);
         end
      end
   end

   // receiver stalls and long hold-off
   always @(posedge clock) begin
      if (hold_left > 0) begin
         rsp_ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else begin
         rsp_ready <= !(idle_on && $urandom_range(99) < 16);
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)
          || (!req_valid && expected_pixels.size() == 0)) begin
         stall_count <= 0;
      end else begin
         stall_count <= stall_count + 1;
         if (stall_count >= STALL_LIMIT) begin
            $display("separable_gaussian_blur verification failed");
            $finish;
         end
      end
   end

   task automatic send_request(bit act, logic [7:0] pix);
      req_type rq;
      rq.action = act;
      rq.pixel_in = pix;
      if (idle_on && $urandom_range(99) < 16) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= rq;
      do @(posedge clock); while (!req_ready);
      blur_request(rq);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (expected_pixels.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(csr_index_type idx, logic [15:0] value);
      wait_drained();
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_COEF_CENTER:  blur_coef[0] = value;
         CSR_COEF_ONE:     blur_coef[1] = value;
         CSR_COEF_TWO:     blur_coef[2] = value;
         CSR_COEF_THREE:   blur_coef[3] = value;
         CSR_RADIUS: begin
            blur_radius = value[1:0];
            clear_frame();
         end
         CSR_FRAME_WIDTH: begin
            blur_width = value[11:0];
            clear_frame();
         end
         CSR_FRAME_HEIGHT: begin
            blur_height = value[12:0];
            clear_frame();
         end
         default: ;
      endcase
   endtask

   task automatic set_geometry(logic [1:0] r, logic [11:0] w, logic [12:0] h);
      write_csr(CSR_RADIUS, 16'(r));
      write_csr(CSR_FRAME_WIDTH, 16'(w));
      write_csr(CSR_FRAME_HEIGHT, 16'(h));
   endtask

   task automatic set_coefs(logic [15:0] c0, logic [15:0] c1, logic [15:0] c2,
                            logic [15:0] c3);
      write_csr(CSR_COEF_CENTER, c0);
      write_csr(CSR_COEF_ONE, c1);
      write_csr(CSR_COEF_TWO, c2);
      write_csr(CSR_COEF_THREE, c3);
   endtask

   // full frame then flushes; pix_mode 0 random, 1 all 255, 2 all 0
   task automatic run_frame(int pix_mode, int noise_pct, output int sent);
      int n;
      logic [7:0] p;
      sent = 0;
      n = eff_width() * eff_height();
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(99) < noise_pct) begin
            send_request(1'b1, 8'($urandom));
            sent++;
         end
         p = (pix_mode == 1) ? 8'hFF : (pix_mode == 2) ? 8'h00 : 8'($urandom);
         send_request(1'b0, p);
         sent++;
      end
      while (!frame_idle()) begin
         send_request($urandom_range(99) < 80, 8'($urandom));
         sent++;
      end
   endtask

   // start of a frame only, abandoned by the next geometry write
   task automatic run_partial(int count);
      for (int i = 0; i < count; i++) send_request(1'b0, 8'($urandom));
   endtask

   task automatic test_directed();
      int s;
      set_geometry(2'd0, 12'd0, 13'd0);
      send_request(1'b1, 8'h00);
      send_request(1'b0, 8'hFF);
      send_request(1'b1, 8'hFF);
      set_geometry(2'd1, 12'd3, 13'd2);
      run_frame(1, 0, s);
      run_frame(2, 0, s);
      set_geometry(2'd3, 12'd4, 13'd3);
      run_frame(0, 20, s);
   endtask

   task automatic test_saturation();
      int s;
      set_coefs(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      set_geometry(2'd3, 12'd7, 13'd7);
      run_frame(1, 0, s);
      set_coefs(16'h0000, 16'h0000, 16'h0000, 16'h0000);
      run_frame(1, 0, s);
      set_coefs(16'd34236, 16'd15663, 16'd0, 16'd0);
   endtask

   task automatic test_abandon_frame();
      int s;
      set_geometry(2'd1, 12'd5, 13'd4);
      for (int i = 0; i < 7; i++) send_request(1'b0, 8'($urandom));
      write_csr(CSR_FRAME_WIDTH, 16'd6);
      run_frame(0, 0, s);
   endtask

   task automatic test_large_sizes();
      set_geometry(2'd3, 12'd4095, 13'd1);
      run_partial(16);
      set_geometry(2'd2, 12'd2048, 13'd2);
      run_partial(16);
      set_geometry(2'd2, 12'd1, 13'd8191);
      run_partial(16);
      set_geometry(2'd1, 12'd1, 13'd4096);
      run_partial(16);
   endtask

   task automatic test_backpressure();
      int s;
      set_geometry(2'd2, 12'd8, 13'd6);
      hold_left = 300;
      run_frame(0, 0, s);
   endtask

   task automatic test_random();
      int s;
      idle_on = 1'b0;
      while (random_sent < RANDOM_ITEMS) begin
         if (random_sent > 30) idle_on = 1'b1;
         if ($urandom_range(99) < 40)
            set_coefs(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
         set_geometry(2'($urandom), 12'($urandom_range(1, 12)),
                      13'($urandom_range(1, 8)));
         run_frame(0, 8, s);
         random_sent += s;
      end
   endtask

   initial begin
      for (int i = 0; i < 7*STORE_W; i++) line_mem[i] = '0;
      for (int i = 0; i < 7; i++) pix_window[i] = '0;
      blur_coef[0] = 16'd34236;
      blur_coef[1] = 16'd15663;
      blur_coef[2] = 16'd0;
      blur_coef[3] = 16'd0;
      blur_radius = 2'd1;
      blur_width = 12'd640;
      blur_height = 13'd480;
      clear_frame();
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_saturation();
      test_abandon_frame();
      test_backpressure();
      test_large_sizes();
      test_random();
      wait_drained();
      repeat (10) @(posedge clock);
      if (errors == 0) begin
         $display("separable_gaussian_blur verification clean");
      end else begin
         $display("separable_gaussian_blur verification failed");
      end
      $finish;
   end
endmodule

FILE: sim.f
design/sgb_pkg.sv
design/sgb_hpass.sv
design/sgb_vpass.sv
design/separable_gaussian_blur.sv
dv/tb_top.sv
